FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands, clocked on clk with synchronous rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, ante, cons)
`define ASSERT_NEVER(label, expr)
`endif

`endif

FILE: rtl/dsi_pkg.sv
// ---------------------------------------------------------------------------
// Drive safety interlock package
// Action codes, register indexes, fixed-point limits and shared types.
// ---------------------------------------------------------------------------
package dsi_pkg;

  typedef enum logic [2:0] {
    ACT_DRIVE  = 3'd0,
    ACT_ARM    = 3'd1,
    ACT_DISARM = 3'd2,
    ACT_ESTOP  = 3'd3,
    ACT_CLEAR  = 3'd4,
    ACT_TICK   = 3'd5
  } dsi_action_t;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WDT_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_AT_RESET = 1'd1;

  localparam logic [15:0] WDT_RESET = 16'd500;

  localparam logic signed [15:0] Q_ONE = 16'sd16384;
  localparam logic signed [15:0] Q_NEG_ONE = -16'sd16384;
  localparam logic signed [15:0] Q_ZERO = 16'sd0;

  localparam logic [16:0] IDLE_MAX = 17'h1FFFF;

  typedef struct packed {
    logic [2:0]         action;
    logic               has_steer;
    logic signed [15:0] steer;
    logic               has_throttle;
    logic signed [15:0] throttle;
  } dsi_item_t;

  typedef struct packed {
    logic signed [15:0] steer;
    logic signed [15:0] throttle;
    logic               armed;
    logic               estop;
    logic               forced;
    logic               expired;
  } dsi_result_t;

  function automatic logic signed [15:0] clamp_unit(input logic signed [15:0] v);
    logic signed [15:0] r;
    if (v > Q_ONE) begin
      r = Q_ONE;
    end else if (v < Q_NEG_ONE) begin
      r = Q_NEG_ONE;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: rtl/drive_safety_interlock.sv
// ---------------------------------------------------------------------------
// Drive safety interlock
// Arm/disarm, e-stop latch and idle watchdog in front of steer and throttle.
// ---------------------------------------------------------------------------
// One transaction is accepted per clock while in_stall is low, and each one
// returns exactly one result transaction: the input register feeds a
// combinational state update whose result is captured in the output
// register, and back-to-back transactions run at full rate while out_stall
// is low. out_stall holds the output register and, once the input register
// is also full, raises in_stall. Configuration is written through cfg_we
// with no read-back; the user must write it only while no transaction is in
// flight, which the block itself does not enforce. Writing the arm-at-reset
// index loads cfg_wdata[0] into the armed flag unless e-stop is latched.
`include "assert_macros.svh"

module drive_safety_interlock import dsi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_action,
  input  logic                  in_has_steer,
  input  logic signed [15:0]    in_steer_in,
  input  logic                  in_has_throttle,
  input  logic signed [15:0]    in_throttle_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    out_steer_out,
  output logic signed [15:0]    out_throttle_out,
  output logic                  out_armed_now,
  output logic                  out_estop_now,
  output logic                  out_forced_safe,
  output logic                  out_watchdog_expired
);

  dsi_item_t   item_r;
  logic        s1_valid_r, s1_valid_nxt;
  dsi_result_t res_r;
  dsi_result_t res;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free, s1_adv, in_fire;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= '{action:       in_action,
                  has_steer:    in_has_steer,
                  steer:        in_steer_in,
                  has_throttle: in_has_throttle,
                  throttle:     in_throttle_in};
    end
    if (s1_adv) begin
      res_r <= res;
    end
  end

  dsi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item_fire (s1_adv),
    .item      (item_r),
    .result    (res)
  );

  assign out_valid            = out_valid_r;
  assign out_steer_out        = res_r.steer;
  assign out_throttle_out     = res_r.throttle;
  assign out_armed_now        = res_r.armed;
  assign out_estop_now        = res_r.estop;
  assign out_forced_safe      = res_r.forced;
  assign out_watchdog_expired = res_r.expired;

  `ASSERT_NEVER(a_latch_not_armed, out_valid_r && res_r.estop && res_r.armed)
  `ASSERT_IMPLY(a_forced_neutral, out_valid_r && res_r.forced, {res_r.steer, res_r.throttle} == '0)
  `ASSERT_IMPLY(a_expired_forced, out_valid_r && res_r.expired, res_r.forced && !res_r.estop)
  `ASSERT_IMPLY(a_steer_range, out_valid_r, res_r.steer <= Q_ONE && res_r.steer >= Q_NEG_ONE)

endmodule

FILE: rtl/dsi_ctrl.sv
// ---------------------------------------------------------------------------
// Interlock state and update logic
// Holds arming, latch, timeout, idle count, held outputs; computes one result.
// ---------------------------------------------------------------------------
module dsi_ctrl import dsi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  item_fire,
  input  dsi_item_t             item,
  output dsi_result_t           result
);

  logic [15:0]        wdt_r;
  logic               armed_r, armed_nxt;
  logic               estop_r, estop_nxt;
  logic [16:0]        idle_r, idle_nxt;
  logic signed [15:0] steer_r, steer_nxt;
  logic signed [15:0] throttle_r, throttle_nxt;
  logic               forced, expired;
  logic [16:0]        idle_inc;

  assign idle_inc = (idle_r == IDLE_MAX) ? idle_r : idle_r + 17'd1;

  always_comb begin
    armed_nxt    = armed_r;
    estop_nxt    = estop_r;
    idle_nxt     = idle_r;
    steer_nxt    = steer_r;
    throttle_nxt = throttle_r;
    forced       = 1'b0;
    expired      = 1'b0;
    case (dsi_action_t'(item.action))
      ACT_DRIVE: begin
        idle_nxt = '0;
        if (!estop_r && armed_r) begin
          if (item.has_steer) steer_nxt = clamp_unit(item.steer);
          if (item.has_throttle) throttle_nxt = clamp_unit(item.throttle);
        end
      end
      ACT_ARM: begin
        if (!estop_r) armed_nxt = 1'b1;
      end
      ACT_DISARM: begin
        if (!estop_r) begin
          armed_nxt = 1'b0;
          forced    = 1'b1;
        end
      end
      ACT_ESTOP: begin
        estop_nxt = 1'b1;
        armed_nxt = 1'b0;
        forced    = 1'b1;
      end
      ACT_CLEAR: begin
        estop_nxt = 1'b0;
        forced    = 1'b1;
      end
      ACT_TICK: begin
        idle_nxt = idle_inc;
        if (estop_r || !armed_r) begin
          forced = 1'b1;
        end else if (wdt_r != 16'd0 && idle_inc > {1'b0, wdt_r}) begin
          forced  = 1'b1;
          expired = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (forced) begin
      steer_nxt    = Q_ZERO;
      throttle_nxt = Q_ZERO;
    end
  end

  assign result = '{steer:    steer_nxt,
                    throttle: throttle_nxt,
                    armed:    armed_nxt,
                    estop:    estop_nxt,
                    forced:   forced,
                    expired:  expired};

  // the armed flag resets to 0; arm-at-reset is a write port with no register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wdt_r      <= WDT_RESET;
      armed_r    <= 1'b0;
      estop_r    <= 1'b0;
      idle_r     <= '0;
      steer_r    <= Q_ZERO;
      throttle_r <= Q_ZERO;
    end else if (item_fire) begin
      armed_r    <= armed_nxt;
      estop_r    <= estop_nxt;
      idle_r     <= idle_nxt;
      steer_r    <= steer_nxt;
      throttle_r <= throttle_nxt;
    end else if (cfg_we) begin
      if (cfg_index == REG_WDT_TIMEOUT) begin
        wdt_r <= cfg_wdata;
      end else if (cfg_index == REG_ARM_AT_RESET) begin
        if (!estop_r) armed_r <= cfg_wdata[0];
      end
    end
  end

endmodule
